@@ rtl/lqrtr_pkg.sv @@
package lqrtr_pkg;

  // Field widths fixed by the interface
  localparam int IO_W   = 32;
  localparam int GAIN_W = 16;
  localparam int CNT_W  = 7;
  localparam int NUM_AXES = 3;

  // Q0.16 step constants: 0.2 and 0.02
  localparam logic signed [15:0] K_DT       = 16'sd13107;
  localparam logic signed [15:0] K_HALF_DT2 = 16'sd1311;

  // Fraction bits dropped after the gain product (Q4.12 gain)
  localparam int GAIN_FRAC = 12;
  localparam int DT_FRAC   = 16;

  // Register map, word index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_GAIN_PX = 3'd0,
    REG_GAIN_VX = 3'd1,
    REG_GAIN_PY = 3'd2,
    REG_GAIN_VY = 3'd3,
    REG_GAIN_PZ = 3'd4,
    REG_GAIN_VZ = 3'd5,
    REG_STEPS   = 3'd6,
    REG_END_IDX = 3'd7
  } lqrtr_reg_t;

  localparam logic signed [GAIN_W-1:0] RST_GAIN_POS = 16'sd2121;
  localparam logic signed [GAIN_W-1:0] RST_GAIN_VEL = 16'sd4222;
  localparam logic [CNT_W-1:0]         RST_STEPS    = 7'd9;
  localparam logic [CNT_W-1:0]         RST_END_IDX  = 7'd5;

  // Controller to datapath commands, one enable per pipeline phase
  typedef struct packed {
    logic load;
    logic err_en;
    logic mul_en;
    logic u_en;
    logic prod_en;
    logic upd_en;
  } lqrtr_cmd_t;

endpackage

@@ rtl/lqrtr_ctrl.sv @@
module lqrtr_ctrl import lqrtr_pkg::*; #(
  parameter int MAX_STEPS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CNT_W-1:0] step_count,
  input  logic [CNT_W-1:0] end_index,
  output logic             busy,
  output lqrtr_cmd_t       cmd,
  output logic             out_valid,
  output logic             is_end_state,
  output logic             is_last
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL,
    ST_U,
    ST_PROD,
    ST_UPD
  } state_t;

  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_STEPS);

  state_t           state_r;
  logic [CNT_W-1:0] steps_r;
  logic [CNT_W-1:0] endi_r;
  logic [CNT_W-1:0] k_r;
  logic [CNT_W-1:0] k_nxt;
  logic [CNT_W-1:0] steps_c;
  logic [CNT_W-1:0] endi_c;
  logic             out_valid_r;
  logic             is_end_r;
  logic             is_last_r;

  // Clamp run length and end-state step at request time
  always_comb begin
    if (step_count == '0) begin
      steps_c = CNT_W'(1);
    end else if (step_count > MAX_C) begin
      steps_c = MAX_C;
    end else begin
      steps_c = step_count;
    end
    if (end_index == '0) begin
      endi_c = CNT_W'(1);
    end else if (end_index > steps_c) begin
      endi_c = steps_c;
    end else begin
      endi_c = end_index;
    end
  end

  assign k_nxt = k_r + CNT_W'(1);

  // Phase decode
  always_comb begin
    cmd         = '0;
    cmd.load    = (state_r == ST_IDLE) && start;
    cmd.err_en  = (state_r == ST_ERR);
    cmd.mul_en  = (state_r == ST_MUL);
    cmd.u_en    = (state_r == ST_U);
    cmd.prod_en = (state_r == ST_PROD);
    cmd.upd_en  = (state_r == ST_UPD);
  end

  // Sequencer: one step per pass through the five phases
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      steps_r     <= '0;
      endi_r      <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      is_end_r    <= 1'b0;
      is_last_r   <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_UPD);
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            steps_r <= steps_c;
            endi_r  <= endi_c;
            k_r     <= '0;
            state_r <= ST_ERR;
          end
        end
        ST_ERR:  state_r <= ST_MUL;
        ST_MUL:  state_r <= ST_U;
        ST_U:    state_r <= ST_PROD;
        ST_PROD: state_r <= ST_UPD;
        ST_UPD: begin
          k_r         <= k_nxt;
          is_end_r    <= (k_nxt == endi_r);
          is_last_r   <= (k_nxt == steps_r);
          state_r     <= (k_nxt == steps_r) ? ST_IDLE : ST_ERR;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy         = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign is_end_state = is_end_r;
  assign is_last      = is_last_r;

endmodule

@@ rtl/lqrtr_dp.sv @@
module lqrtr_dp import lqrtr_pkg::*; #(
  parameter int STATE_WIDTH = 32
) (
  input  logic                     clk,
  input  lqrtr_cmd_t               cmd,
  input  logic signed [IO_W-1:0]   start_p [NUM_AXES],
  input  logic signed [IO_W-1:0]   start_v [NUM_AXES],
  input  logic signed [IO_W-1:0]   goal_p  [NUM_AXES],
  input  logic signed [IO_W-1:0]   goal_v  [NUM_AXES],
  input  logic signed [GAIN_W-1:0] gain_p  [NUM_AXES],
  input  logic signed [GAIN_W-1:0] gain_v  [NUM_AXES],
  output logic [IO_W-1:0]          way_p   [NUM_AXES],
  output logic [IO_W-1:0]          way_v   [NUM_AXES]
);

  localparam int SW   = STATE_WIDTH;
  localparam int WW   = SW + 56;                  // common width for saturation
  localparam int OW   = (SW > IO_W) ? SW : IO_W;  // output extension width
  localparam int PW   = SW + GAIN_W;              // product width
  localparam int SUMW = PW + 1;
  localparam int SUMX = (SUMW > 65) ? SUMW : 65;
  localparam int RW   = 64 - GAIN_FRAC + 1;       // rounded gain sum width
  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  // Clamp to the signed state range
  function automatic logic signed [SW-1:0] sat_sw(input logic signed [WW-1:0] x);
    logic signed [WW-1:0] hi;
    logic signed [WW-1:0] lo;
    hi = {{(WW - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
    lo = ~hi;
    if (x > hi) begin
      return hi[SW-1:0];
    end else if (x < lo) begin
      return lo[SW-1:0];
    end
    return x[SW-1:0];
  endfunction

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    logic signed [SW-1:0]     p_r, v_r, gp_r, gv_r;
    logic signed [SW-1:0]     ep_r, ev_r, u_r;
    logic signed [PW-1:0]     kv_r, mp_r, mv_r, hu_r, ku_r;
    logic signed [SUMX-1:0]   sum_x;
    logic signed [63:0]       s64;
    logic signed [RW-1:0]     r_g;
    logic signed [SUMW-1:0]   d1;
    logic signed [SW+1:0]     dp;
    logic signed [SW:0]       dv;
    logic signed [OW-1:0]     p_ext, v_ext;

    // Gain sum, saturated to 64 bits, then rounded half up by 2^12
    always_comb begin
      sum_x = SUMX'(mp_r) + SUMX'(mv_r);
      if (sum_x > SUMX'(S64_MAX)) begin
        s64 = S64_MAX;
      end else if (sum_x < SUMX'(S64_MIN)) begin
        s64 = S64_MIN;
      end else begin
        s64 = sum_x[63:0];
      end
      r_g = RW'(s64 >>> GAIN_FRAC) + RW'($signed({1'b0, s64[GAIN_FRAC-1]}));
    end

    // Position and velocity increments, rounded half up by 2^16
    always_comb begin
      d1 = SUMW'(kv_r) + SUMW'(hu_r);
      dp = (SW+2)'(d1 >>> DT_FRAC) + (SW+2)'($signed({1'b0, d1[DT_FRAC-1]}));
      dv = (SW+1)'(ku_r >>> DT_FRAC) + (SW+1)'($signed({1'b0, ku_r[DT_FRAC-1]}));
    end

    // Step pipeline, one phase enabled at a time
    always_ff @(posedge clk) begin
      if (cmd.load) begin
        p_r  <= sat_sw(WW'(start_p[a]));
        v_r  <= sat_sw(WW'(start_v[a]));
        gp_r <= sat_sw(WW'(goal_p[a]));
        gv_r <= sat_sw(WW'(goal_v[a]));
      end
      if (cmd.err_en) begin
        ep_r <= sat_sw(WW'(p_r) - WW'(gp_r));
        ev_r <= sat_sw(WW'(v_r) - WW'(gv_r));
        kv_r <= PW'(v_r) * PW'(K_DT);
      end
      if (cmd.mul_en) begin
        mp_r <= PW'(gain_p[a]) * PW'(ep_r);
        mv_r <= PW'(gain_v[a]) * PW'(ev_r);
      end
      if (cmd.u_en) begin
        u_r <= sat_sw(-WW'(r_g));
      end
      if (cmd.prod_en) begin
        hu_r <= PW'(u_r) * PW'(K_HALF_DT2);
        ku_r <= PW'(u_r) * PW'(K_DT);
      end
      if (cmd.upd_en) begin
        p_r <= sat_sw(WW'(p_r) + WW'(dp));
        v_r <= sat_sw(WW'(v_r) + WW'(dv));
      end
    end

    // Waypoint word: low 32 bits of the sign-extended state
    assign p_ext     = OW'(p_r);
    assign v_ext     = OW'(v_r);
    assign way_p[a]  = p_ext[IO_W-1:0];
    assign way_v[a]  = v_ext[IO_W-1:0];
  end

endmodule

@@ rtl/lqr_trajectory_rollout.sv @@
// Each waypoint word is the result of one pass through the five-phase step loop of the
// gain/update datapath; a request runs one step per waypoint, with step_count clamped
// to 1..MAX_STEPS. No new start is taken while busy; a new start is taken in the cycle
// the last waypoint is shown.
// Waypoints are strobed by out_valid for one cycle; the receiver cannot stall.
// Reset (rst_n low, synchronous) idles the sequencer and loads default gains and counts.
module lqr_trajectory_rollout import lqrtr_pkg::*; #(
  parameter int MAX_STEPS   = 64,
  parameter int STATE_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // request
  input  logic                     start,
  output logic                     busy,
  input  logic signed [IO_W-1:0]   in_start_px,
  input  logic signed [IO_W-1:0]   in_start_vx,
  input  logic signed [IO_W-1:0]   in_start_py,
  input  logic signed [IO_W-1:0]   in_start_vy,
  input  logic signed [IO_W-1:0]   in_start_pz,
  input  logic signed [IO_W-1:0]   in_start_vz,
  input  logic signed [IO_W-1:0]   in_goal_px,
  input  logic signed [IO_W-1:0]   in_goal_vx,
  input  logic signed [IO_W-1:0]   in_goal_py,
  input  logic signed [IO_W-1:0]   in_goal_vy,
  input  logic signed [IO_W-1:0]   in_goal_pz,
  input  logic signed [IO_W-1:0]   in_goal_vz,
  // waypoints
  output logic                     out_valid,
  output logic signed [IO_W-1:0]   out_way_px,
  output logic signed [IO_W-1:0]   out_way_vx,
  output logic signed [IO_W-1:0]   out_way_py,
  output logic signed [IO_W-1:0]   out_way_vy,
  output logic signed [IO_W-1:0]   out_way_pz,
  output logic signed [IO_W-1:0]   out_way_vz,
  output logic                     out_is_end_state,
  output logic                     out_is_last,
  // register port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [4:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic signed [GAIN_W-1:0] gain_px_r, gain_vx_r, gain_py_r, gain_vy_r;
  logic signed [GAIN_W-1:0] gain_pz_r, gain_vz_r;
  logic [CNT_W-1:0]         step_count_r;
  logic [CNT_W-1:0]         end_index_r;
  logic                     cfg_wr;
  lqrtr_reg_t               cfg_idx;
  lqrtr_cmd_t               cmd;

  logic signed [IO_W-1:0]   start_p [NUM_AXES];
  logic signed [IO_W-1:0]   start_v [NUM_AXES];
  logic signed [IO_W-1:0]   goal_p  [NUM_AXES];
  logic signed [IO_W-1:0]   goal_v  [NUM_AXES];
  logic signed [GAIN_W-1:0] gain_p  [NUM_AXES];
  logic signed [GAIN_W-1:0] gain_v  [NUM_AXES];
  logic [IO_W-1:0]          way_p   [NUM_AXES];
  logic [IO_W-1:0]          way_v   [NUM_AXES];

  // Register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = lqrtr_reg_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_px_r    <= RST_GAIN_POS;
      gain_vx_r    <= RST_GAIN_VEL;
      gain_py_r    <= RST_GAIN_POS;
      gain_vy_r    <= RST_GAIN_VEL;
      gain_pz_r    <= RST_GAIN_POS;
      gain_vz_r    <= RST_GAIN_VEL;
      step_count_r <= RST_STEPS;
      end_index_r  <= RST_END_IDX;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_GAIN_PX: gain_px_r    <= pwdata[GAIN_W-1:0];
        REG_GAIN_VX: gain_vx_r    <= pwdata[GAIN_W-1:0];
        REG_GAIN_PY: gain_py_r    <= pwdata[GAIN_W-1:0];
        REG_GAIN_VY: gain_vy_r    <= pwdata[GAIN_W-1:0];
        REG_GAIN_PZ: gain_pz_r    <= pwdata[GAIN_W-1:0];
        REG_GAIN_VZ: gain_vz_r    <= pwdata[GAIN_W-1:0];
        REG_STEPS:   step_count_r <= pwdata[CNT_W-1:0];
        REG_END_IDX: end_index_r  <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    case (cfg_idx)
      REG_GAIN_PX: prdata = 32'(unsigned'(gain_px_r));
      REG_GAIN_VX: prdata = 32'(unsigned'(gain_vx_r));
      REG_GAIN_PY: prdata = 32'(unsigned'(gain_py_r));
      REG_GAIN_VY: prdata = 32'(unsigned'(gain_vy_r));
      REG_GAIN_PZ: prdata = 32'(unsigned'(gain_pz_r));
      REG_GAIN_VZ: prdata = 32'(unsigned'(gain_vz_r));
      REG_STEPS:   prdata = 32'(step_count_r);
      REG_END_IDX: prdata = 32'(end_index_r);
      default:     prdata = '0;
    endcase
  end

  // Axis lanes: x, y, z
  assign start_p = '{in_start_px, in_start_py, in_start_pz};
  assign start_v = '{in_start_vx, in_start_vy, in_start_vz};
  assign goal_p  = '{in_goal_px, in_goal_py, in_goal_pz};
  assign goal_v  = '{in_goal_vx, in_goal_vy, in_goal_vz};
  assign gain_p  = '{gain_px_r, gain_py_r, gain_pz_r};
  assign gain_v  = '{gain_vx_r, gain_vy_r, gain_vz_r};

  lqrtr_ctrl #(
    .MAX_STEPS (MAX_STEPS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .step_count   (step_count_r),
    .end_index    (end_index_r),
    .busy         (busy),
    .cmd          (cmd),
    .out_valid    (out_valid),
    .is_end_state (out_is_end_state),
    .is_last      (out_is_last)
  );

  lqrtr_dp #(
    .STATE_WIDTH (STATE_WIDTH)
  ) u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .start_p (start_p),
    .start_v (start_v),
    .goal_p  (goal_p),
    .goal_v  (goal_v),
    .gain_p  (gain_p),
    .gain_v  (gain_v),
    .way_p   (way_p),
    .way_v   (way_v)
  );

  assign out_way_px = way_p[0];
  assign out_way_py = way_p[1];
  assign out_way_pz = way_p[2];
  assign out_way_vx = way_v[0];
  assign out_way_vy = way_v[1];
  assign out_way_vz = way_v[2];

`ifndef SYNTH
  // A waypoint word only follows a cycle of step work
  a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("waypoint strobe without a running request");

  // A taken request starts the sequencer
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request taken but sequencer idle");

  // The last waypoint releases the request channel
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_last) |-> !busy)
    else $error("still busy on last waypoint");

  // No second strobe in the cycle after a waypoint
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back waypoint strobes");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import lqrtr_pkg::*;

  // Start/goal word: index 0..5 start p,v for x,y,z; 6..11 goal p,v for x,y,z
  typedef logic [11:0][IO_W-1:0] rollout_req_t;

  typedef struct packed {
    logic [5:0][IO_W-1:0] st;
    logic                 end_flag;
    logic                 last_flag;
  } waypoint_t;

  localparam int     LIMIT_CYCLES = 400000;
  localparam int     MAX_ROLL     = 64;
  localparam int     DRAIN_CYCLES = 20;
  localparam int     RAND_ITEMS   = 90;
  localparam longint STATE_MAX    = 64'sd2147483647;
  localparam longint STATE_MIN    = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   start = 1'b0;
  logic                   busy;
  logic signed [IO_W-1:0] in_start_px = '0;
  logic signed [IO_W-1:0] in_start_vx = '0;
  logic signed [IO_W-1:0] in_start_py = '0;
  logic signed [IO_W-1:0] in_start_vy = '0;
  logic signed [IO_W-1:0] in_start_pz = '0;
  logic signed [IO_W-1:0] in_start_vz = '0;
  logic signed [IO_W-1:0] in_goal_px = '0;
  logic signed [IO_W-1:0] in_goal_vx = '0;
  logic signed [IO_W-1:0] in_goal_py = '0;
  logic signed [IO_W-1:0] in_goal_vy = '0;
  logic signed [IO_W-1:0] in_goal_pz = '0;
  logic signed [IO_W-1:0] in_goal_vz = '0;

  logic                   out_valid;
  logic signed [IO_W-1:0] out_way_px;
  logic signed [IO_W-1:0] out_way_vx;
  logic signed [IO_W-1:0] out_way_py;
  logic signed [IO_W-1:0] out_way_vy;
  logic signed [IO_W-1:0] out_way_pz;
  logic signed [IO_W-1:0] out_way_vz;
  logic                   out_is_end_state;
  logic                   out_is_last;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lqr_trajectory_rollout u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_start_px      (in_start_px),
    .in_start_vx      (in_start_vx),
    .in_start_py      (in_start_py),
    .in_start_vy      (in_start_vy),
    .in_start_pz      (in_start_pz),
    .in_start_vz      (in_start_vz),
    .in_goal_px       (in_goal_px),
    .in_goal_vx       (in_goal_vx),
    .in_goal_py       (in_goal_py),
    .in_goal_vy       (in_goal_vy),
    .in_goal_pz       (in_goal_pz),
    .in_goal_vz       (in_goal_vz),
    .out_valid        (out_valid),
    .out_way_px       (out_way_px),
    .out_way_vx       (out_way_vx),
    .out_way_py       (out_way_py),
    .out_way_vy       (out_way_vy),
    .out_way_pz       (out_way_pz),
    .out_way_vz       (out_way_vz),
    .out_is_end_state (out_is_end_state),
    .out_is_last      (out_is_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Mirror of the register file
  logic signed [GAIN_W-1:0] gain_m [6] = '{RST_GAIN_POS, RST_GAIN_VEL, RST_GAIN_POS,
                                           RST_GAIN_VEL, RST_GAIN_POS, RST_GAIN_VEL};
  logic [CNT_W-1:0] steps_m = RST_STEPS;
  logic [CNT_W-1:0] end_m   = RST_END_IDX;

  rollout_req_t pending_q [$];
  waypoint_t    waypoint_q [$];

  string way_names [6] = '{"way_px", "way_vx", "way_py", "way_vy", "way_pz", "way_vz"};

  int  issued_cnt = 0;
  int  taken_cnt  = 0;
  int  wp_cnt     = 0;
  int  wr_cnt     = 0;
  int  err_cnt    = 0;
  int  cycle_cnt  = 0;
  int  gap_left   = 0;
  bit  no_idle    = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Append a request word to the driver queue
  function automatic void add_req(rollout_req_t req);
    pending_q.insert(pending_q.size(), req);
  endfunction

  function automatic longint clamp_state(longint x);
    if (x > STATE_MAX) return STATE_MAX;
    if (x < STATE_MIN) return STATE_MIN;
    return x;
  endfunction

  // Arithmetic shift right, rounding half toward plus infinity
  function automatic longint shr_round(longint x, int s);
    return (x >>> s) + ((x >>> (s - 1)) & 64'sd1);
  endfunction

  // Roll the double integrator forward and queue every waypoint it emits
  function automatic void predict_rollout(rollout_req_t req);
    longint    st [6];
    longint    goal [6];
    longint    p, v, ep, ev, sum, u, dp, dv;
    int        n_steps, end_at;
    waypoint_t wp;
    n_steps = int'(steps_m);
    if (n_steps < 1) n_steps = 1;
    if (n_steps > MAX_ROLL) n_steps = MAX_ROLL;
    end_at = int'(end_m);
    if (end_at < 1) end_at = 1;
    if (end_at > n_steps) end_at = n_steps;
    for (int j = 0; j < 6; j++) begin
      st[j]   = longint'($signed(req[j]));
      goal[j] = longint'($signed(req[6 + j]));
    end
    for (int k = 0; k < n_steps; k++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        p  = st[2 * a];
        v  = st[2 * a + 1];
        ep = clamp_state(p - goal[2 * a]);
        ev = clamp_state(v - goal[2 * a + 1]);
        // 16x32 products: the sum stays far inside 64 bits
        sum = longint'(gain_m[2 * a]) * ep + longint'(gain_m[2 * a + 1]) * ev;
        u  = clamp_state(-shr_round(sum, GAIN_FRAC));
        dp = shr_round(longint'(K_DT) * v + longint'(K_HALF_DT2) * u, DT_FRAC);
        dv = shr_round(longint'(K_DT) * u, DT_FRAC);
        st[2 * a]     = clamp_state(p + dp);
        st[2 * a + 1] = clamp_state(v + dv);
      end
      for (int j = 0; j < 6; j++) wp.st[j] = st[j][IO_W-1:0];
      wp.end_flag  = (k + 1 == end_at);
      wp.last_flag = (k + 1 == n_steps);
      waypoint_q.insert(waypoint_q.size(), wp);
    end
  endfunction

  task automatic flag_mismatch(string name, longint exp_v, longint got_v);
    err_cnt++;
    // cap the log on a badly broken design
    if (err_cnt <= 50) $error("%s expected %0d got %0d", name, exp_v, got_v);
  endtask

  // Driver: present pending words at the falling edge, hold start until taken
  always @(negedge clk) begin
    logic         nxt_start;
    rollout_req_t req;
    nxt_start = start;
    if (rst_n) begin
      if (start && taken_cnt == issued_cnt) begin
        nxt_start = 1'b0;
        gap_left  = no_idle ? 0 : $urandom_range(0, 3);
      end else if (!start && gap_left > 0) begin
        gap_left--;
      end
      if (!nxt_start && gap_left == 0 && pending_q.size() > 0) begin
        req = pending_q.pop_front();
        in_start_px <= req[0];
        in_start_vx <= req[1];
        in_start_py <= req[2];
        in_start_vy <= req[3];
        in_start_pz <= req[4];
        in_start_vz <= req[5];
        in_goal_px  <= req[6];
        in_goal_vx  <= req[7];
        in_goal_py  <= req[8];
        in_goal_vy  <= req[9];
        in_goal_pz  <= req[10];
        in_goal_vz  <= req[11];
        issued_cnt++;
        nxt_start = 1'b1;
      end
    end
    start <= nxt_start;
  end

  // Monitor: check waypoints, predict on accepted words, track register writes
  always @(posedge clk) begin
    waypoint_t            exp_wp;
    logic [5:0][IO_W-1:0] got;
    rollout_req_t         req;
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("run exceeded %0d cycles", LIMIT_CYCLES);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else if (rst_n) begin
      if (out_valid) begin
        if (waypoint_q.size() == 0) begin
          err_cnt++;
          $error("waypoint with no request pending: px %0d", out_way_px);
        end else begin
          exp_wp = waypoint_q.pop_front();
          got = {out_way_vz, out_way_pz, out_way_vy, out_way_py, out_way_vx, out_way_px};
          wp_cnt++;
          for (int j = 0; j < 6; j++) begin
            if (got[j] !== exp_wp.st[j])
              flag_mismatch(way_names[j], longint'($signed(exp_wp.st[j])),
                            longint'($signed(got[j])));
          end
          if (out_is_end_state !== exp_wp.end_flag)
            flag_mismatch("is_end_state", longint'(exp_wp.end_flag),
                          longint'(out_is_end_state));
          if (out_is_last !== exp_wp.last_flag)
            flag_mismatch("is_last", longint'(exp_wp.last_flag), longint'(out_is_last));
        end
      end
      if (start && !busy) begin
        req = {in_goal_vz, in_goal_pz, in_goal_vy, in_goal_py, in_goal_vx, in_goal_px,
               in_start_vz, in_start_pz, in_start_vy, in_start_py, in_start_vx, in_start_px};
        predict_rollout(req);
        taken_cnt++;
      end
      if (psel && penable && pwrite && pready) begin
        wr_cnt++;
        case (lqrtr_reg_t'(paddr[4:2]))
          REG_STEPS:   steps_m = pwdata[CNT_W-1:0];
          REG_END_IDX: end_m   = pwdata[CNT_W-1:0];
          default:     gain_m[paddr[4:2]] = pwdata[GAIN_W-1:0];
        endcase
      end
    end
  end

  // Register write: setup phase then access phase
  task automatic cfg_write(lqrtr_reg_t idx, logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || start || waypoint_q.size() != 0 || busy)
      @(posedge clk);
  endtask

  function automatic logic [IO_W-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // Directed words: extremes, equilibrium and bit patterns
  function automatic rollout_req_t dir_req(int kind);
    rollout_req_t req;
    int           sm;
    for (int j = 0; j < 12; j++) begin
      case (kind)
        0:       req[j] = '0;
        1:       req[j] = (j < 6) ? 32'h0001_8000 + j : 32'h0001_8000 + j - 6;
        2:       req[j] = 32'h7fff_ffff;
        3:       req[j] = 32'h8000_0000;
        4:       req[j] = (j < 6) ? 32'h7fff_ffff : 32'h8000_0000;
        5:       req[j] = (j < 6) ? 32'h8000_0000 : 32'h7fff_ffff;
        6:       req[j] = j[0] ? 32'h8000_0000 : 32'h7fff_ffff;
        7:       req[j] = j[0] ? 32'haaaa_aaaa : 32'h5555_5555;
        default: req[j] = (j == 0) ? 32'h0001_0000 : '0;
      endcase
    end
    // equilibrium: goal equals start, random small state
    if (kind == 1) begin
      for (int j = 0; j < 6; j++) begin
        sm = int'($urandom_range(0, 1 << 21)) - (1 << 20);
        req[j]     = sm;
        req[6 + j] = sm;
      end
    end
    return req;
  endfunction

  // Random word: tidy trajectories mostly, else raw noise and extremes
  function automatic rollout_req_t rand_req(bit tidy);
    rollout_req_t req;
    int           sm;
    for (int j = 0; j < 12; j++) begin
      if (tidy) begin
        if (j[0]) sm = int'($urandom_range(0, 1 << 20)) - (1 << 19);
        else      sm = int'($urandom_range(0, 1 << 23)) - (1 << 22);
        req[j] = sm;
      end else begin
        case ($urandom_range(0, 4))
          0:       req[j] = pick_extreme();
          1:       req[j] = int'($urandom_range(0, 1 << 16)) - (1 << 15);
          default: req[j] = $urandom;
        endcase
      end
    end
    return req;
  endfunction

  // Main sequence
  initial begin
    int          n_rand;
    int          n_phase;
    logic [31:0] val;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset register values
    for (int k = 0; k <= 8; k++) add_req(dir_req(k));
    wait_drained();

    // zero step count and zero end index both act as one
    cfg_write(REG_STEPS, 32'd0);
    cfg_write(REG_END_IDX, 32'd0);
    add_req(dir_req(2));
    add_req(dir_req(8));
    wait_drained();

    // longest rollout, extreme gains, end on the last step
    cfg_write(REG_GAIN_PX, 32'h0000_7fff);
    cfg_write(REG_GAIN_VX, 32'hffff_8000);
    cfg_write(REG_GAIN_PY, 32'h0000_7fff);
    cfg_write(REG_GAIN_VY, 32'hffff_8000);
    cfg_write(REG_GAIN_PZ, 32'h0000_7fff);
    cfg_write(REG_GAIN_VZ, 32'hffff_8000);
    cfg_write(REG_STEPS, 32'd64);
    cfg_write(REG_END_IDX, 32'd64);
    add_req(dir_req(4));
    add_req(dir_req(8));
    wait_drained();

    // step count above the maximum saturates
    cfg_write(REG_GAIN_PX, 32'h0000_8000);
    cfg_write(REG_GAIN_VX, 32'h0000_7fff);
    cfg_write(REG_GAIN_PZ, 32'h0000_8000);
    cfg_write(REG_STEPS, 32'd127);
    cfg_write(REG_END_IDX, 32'd100);
    add_req(dir_req(5));
    add_req(dir_req(6));
    wait_drained();

    // end index beyond the step count clamps to it
    cfg_write(REG_GAIN_PY, 32'd0);
    cfg_write(REG_GAIN_VY, 32'd0);
    cfg_write(REG_STEPS, 32'd3);
    cfg_write(REG_END_IDX, 32'd127);
    add_req(dir_req(7));
    add_req(dir_req(1));
    wait_drained();

    // random phases, each with its own register setting and idle mode
    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      wait_drained();
      for (int i = 0; i < 8; i++) begin
        if (i < 6) begin
          if ($urandom_range(0, 9) < 6) val = $urandom_range(0, 8192);
          else                          val = $urandom;
        end else begin
          case ($urandom_range(0, 9))
            0:       val = 32'd0;
            1:       val = $urandom_range(11, 127);
            default: val = $urandom_range(1, 10);
          endcase
          if (i == 7 && $urandom_range(0, 3) == 0) val = $urandom_range(0, 127);
          val[31:CNT_W] = (32 - CNT_W)'($urandom);
        end
        cfg_write(lqrtr_reg_t'(i), val);
      end
      no_idle = ($urandom_range(0, 3) == 0);
      n_phase = $urandom_range(6, 14);
      repeat (n_phase) begin
        add_req(rand_req($urandom_range(0, 9) < 7));
        n_rand++;
      end
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (waypoint_q.size() != 0) begin
      err_cnt++;
      $error("%0d waypoints never arrived", waypoint_q.size());
    end
    $display("covered %0d rollout requests, %0d waypoints checked, %0d register writes",
             taken_cnt, wp_cnt, wr_cnt);
    $display("step counts from zero to 127, saturating gains, %0d mismatches", err_cnt);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/lqrtr_pkg.sv
rtl/lqrtr_ctrl.sv
rtl/lqrtr_dp.sv
rtl/lqr_trajectory_rollout.sv
tb/tb.sv
